// ----- rtl/core/prime_gap_tracker_defines.svh -----
// Assertion shorthands shared by the prime gap tracker modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef PRIME_GAP_TRACKER_DEFINES_SVH
`define PRIME_GAP_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pgt_pkg.sv -----
`default_nettype none

package pgt_pkg;

    // Width of every field on the stream ports.
    localparam int DATA_BITS = 32;

    // Trial division starts at the smallest prime.
    localparam int FIRST_DIVISOR = 2;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_FINISH = 4'b1000
    } seq_state_t;

    // Outcome of one primality test, handed to the gap tracking state.
    typedef struct packed {
        logic commit;
        logic is_prime;
    } verdict_t;

endpackage

`default_nettype wire

// ----- rtl/core/prime_gap_tracker.sv -----
// Candidates below two go straight to the finish state; any other candidate runs
// one division per trial divisor tried, at most about sqrt(n) divisors in all.
// Throughput: one candidate at a time; each divisor costs a full divider run of
// VALUE_BITS quotient bits, a registered completion and a check state.
// A finished result waits in the output register while the next candidate runs.
// Reset (rst_n, asynchronous, active low) clears the last prime and maximum gap.
`default_nettype none

`include "prime_gap_tracker_defines.svh"

module prime_gap_tracker #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input stream; tdata: candidate[31:0].
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [pgt_pkg::DATA_BITS-1:0]     s_axis_tdata,
    // Result stream; tdata: last_prime[31:0], max_gap[63:32]; tuser: is_prime.
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [2*pgt_pkg::DATA_BITS-1:0]        m_axis_tdata,
    output logic                                   m_axis_tuser
);

    import pgt_pkg::*;

    localparam int W = VALUE_BITS;

    seq_state_t   state_reg, state_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] d_reg, d_next;
    logic         prime_reg, prime_next;
    logic         out_valid_reg;
    logic [2*DATA_BITS-1:0] out_data_reg;
    logic         out_user_reg;

    logic         s_fire;
    logic [W-1:0] cand_w;
    logic         div_start;
    logic         div_done;
    logic [W-1:0] div_quo;
    logic [W-1:0] div_rem;
    logic         commit;
    verdict_t     verdict;
    logic [W-1:0] last_prime_next;
    logic [W-1:0] max_gap_next;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cand_w        = W'(s_axis_tdata);
    assign commit        = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    // Sequencer: one division per divisor, then a bound and remainder check (n >= 2).
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        prime_next = prime_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    n_next = cand_w;
                    d_next = W'(FIRST_DIVISOR);
                    if (cand_w < W'(FIRST_DIVISOR))
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (d_reg > div_quo)
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (div_rem == '0)
                begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    d_next     = d_reg + W'(1);
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_FINISH:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Shared divider; the dividend is loaded in the same cycle the candidate is taken.
    pgt_div_unit #(
        .W (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_next),
        .divisor   (d_next),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Gap tracking state, updated when the result is committed.
    assign verdict.commit   = commit;
    assign verdict.is_prime = prime_reg;

    pgt_gap_update #(
        .W (W)
    ) u_gap (
        .clk             (clk),
        .rst_n           (rst_n),
        .verdict         (verdict),
        .value           (n_reg),
        .last_prime_next (last_prime_next),
        .max_gap_next    (max_gap_next)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        prime_reg <= prime_next;
        if (commit)
        begin
            out_data_reg <= {DATA_BITS'(max_gap_next), DATA_BITS'(last_prime_next)};
            out_user_reg <= prime_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // Assertions.
    `PGT_ASSERT_NEXT(a_accept_leaves_idle, s_fire, state_reg != ST_IDLE, "accepted transfer left sequencer idle")
    `PGT_ASSERT_SAME(a_check_divisor_min, state_reg == ST_CHECK, d_reg >= W'(FIRST_DIVISOR), "divisor below two")
    `PGT_ASSERT_SAME(a_done_while_dividing, div_done, state_reg == ST_DIVIDE, "divider finished outside divide state")
    `PGT_ASSERT_SAME(a_prime_nonzero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[DATA_BITS-1:0] != '0, "prime result with zero last prime")

endmodule

`default_nettype wire

// ----- rtl/core/pgt_div_unit.sv -----
`default_nettype none

// Restoring divider that retires one quotient bit per cycle.
module pgt_div_unit #(
    parameter int W = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic [W-1:0]      quotient,
    output logic [W-1:0]      remainder
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic             take;

    // One shift and conditional subtract step per cycle.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[W-1]};
        take      = (trial >= {1'b0, divisor});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_next = W'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            quo_next = {quo_reg[W-2:0], take};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pgt_gap_update.sv -----
`default_nettype none

// Holds the most recent prime and the largest gap between consecutive primes.
module pgt_gap_update #(
    parameter int W = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pgt_pkg::verdict_t verdict,
    input  wire logic [W-1:0]      value,
    output logic [W-1:0]           last_prime_next,
    output logic [W-1:0]           max_gap_next
);

    import pgt_pkg::*;

    logic [W-1:0] prev_reg;
    logic [W-1:0] gap_reg;
    logic [W-1:0] gap_diff;

    // A prime forms a gap only above an earlier nonzero prime.
    always_comb
    begin
        gap_diff        = value - prev_reg;
        last_prime_next = prev_reg;
        max_gap_next    = gap_reg;
        if (verdict.commit && verdict.is_prime)
        begin
            if ((prev_reg != '0) && (value > prev_reg) && (gap_diff > gap_reg))
            begin
                max_gap_next = gap_diff;
            end
            last_prime_next = value;
        end
    end

    // Tracking state clears to zero, meaning no prime seen yet.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            gap_reg  <= '0;
        end
        else
        begin
            prev_reg <= last_prime_next;
            gap_reg  <= max_gap_next;
        end
    end

endmodule

`default_nettype wire

// ----- sim/tb_prime_gap_tracker.sv -----
`default_nettype none

module tb_prime_gap_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    import pgt_pkg::DATA_BITS;

    // Random candidates are kept to those that need few trial divisors.
    localparam int MAX_DIVISORS   = 300;
    localparam int HOLDOFF_CYCLES = 12000;
    localparam int WATCHDOG_LIMIT = 150000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        bit                 is_prime;
        bit [DATA_BITS-1:0] last_prime;
        bit [DATA_BITS-1:0] max_gap;
    } gap_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_BITS-1:0]   s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [2*DATA_BITS-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    // Candidates waiting to be offered and results the tracker still owes.
    bit [DATA_BITS-1:0] candidates[$];
    gap_result_t        expected_results[$];

    // Predicted tracker state.
    bit [DATA_BITS-1:0] prev_prime = '0;
    bit [DATA_BITS-1:0] widest_gap = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit start_holdoff = 1'b0;
    int holdoff_left  = 0;
    int stall_cycles  = 0;
    int mismatches    = 0;
    int results_seen  = 0;
    int sent_count    = 0;
    int primes_seen   = 0;

    prime_gap_tracker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Trial division as the tracker does it; returns the number of divisors tried.
    function automatic int trial_divide(input bit [DATA_BITS-1:0] n, output bit prime);
        longint unsigned d;
        int              tried;
        tried = 0;
        prime = (n >= 2);
        for (d = 2; prime && d <= n / d; d++)
        begin
            tried++;
            if (n % d == 0)
                prime = 1'b0;
        end
        return tried;
    endfunction

    // Advance the predicted state by one accepted candidate.
    function automatic void predict_gap(input bit [DATA_BITS-1:0] n);
        gap_result_t        r;
        bit                 prime;
        bit [DATA_BITS-1:0] gap;
        void'(trial_divide(n, prime));
        if (prime)
        begin
            // A repeated or lower prime leaves the largest gap alone.
            if (prev_prime != 0 && n > prev_prime)
            begin
                gap = n - prev_prime;
                if (gap > widest_gap)
                    widest_gap = gap;
            end
            prev_prime = n;
            primes_seen++;
        end
        r.is_prime   = prime;
        r.last_prime = prev_prime;
        r.max_gap    = widest_gap;
        expected_results.push_back(r);
    endfunction

    // Mostly increasing runs of candidates, with scattered single values as noise.
    task automatic queue_candidates(input int count);
        int                 added;
        int                 run_len;
        int                 stride;
        bit [DATA_BITS-1:0] value;
        bit                 prime;
        added = 0;
        while (added < count)
        begin
            if ($urandom_range(99) < 75)
            begin
                if ($urandom_range(99) < 70)
                    value = $urandom_range(20000, 0);
                else
                    value = $urandom();
                run_len = $urandom_range(12, 4);
                stride  = $urandom_range(2, 1);
                repeat (run_len)
                begin
                    if (added < count && trial_divide(value, prime) <= MAX_DIVISORS)
                    begin
                        candidates.push_back(value);
                        added++;
                    end
                    value += stride;
                end
            end
            else
            begin
                case ($urandom_range(3))
                    0: value = $urandom_range(1, 0);
                    1: value = (candidates.size() != 0) ? candidates[$] : prev_prime;
                    2: value = $urandom();
                    default: value = $urandom_range(200, 2);
                endcase
                if (trial_divide(value, prime) <= MAX_DIVISORS)
                begin
                    candidates.push_back(value);
                    added++;
                end
            end
        end
    endtask

    // Driver: offer the next candidate and predict on each accepted transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_gap(s_axis_tdata);
                sent_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (candidates.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tdata  <= candidates.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge clk)
    begin
        if (start_holdoff)
            holdoff_left <= HOLDOFF_CYCLES;
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Monitor: compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("ERROR: unexpected result last_prime=%0d max_gap=%0d",
                                 m_axis_tdata[DATA_BITS-1:0], m_axis_tdata[2*DATA_BITS-1:DATA_BITS]);
                end
                else
                begin
                    gap_result_t exp_r;
                    exp_r = expected_results.pop_front();
                    if (m_axis_tuser !== exp_r.is_prime
                        || m_axis_tdata[DATA_BITS-1:0] !== exp_r.last_prime
                        || m_axis_tdata[2*DATA_BITS-1:DATA_BITS] !== exp_r.max_gap)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("ERROR: result %0d: is_prime %b/%b last_prime %0d/%0d max_gap %0d/%0d (expected/actual)",
                                     results_seen, exp_r.is_prime, m_axis_tuser,
                                     exp_r.last_prime, m_axis_tdata[DATA_BITS-1:0],
                                     exp_r.max_gap, m_axis_tdata[2*DATA_BITS-1:DATA_BITS]);
                    end
                end
            end
            m_axis_tready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: values below two, first prime, repeated and lower primes,
        // squares at the divisor bound, a wide gap and the extremes of the field.
        send_idle_pct = 19;
        recv_idle_pct = 84;
        candidates = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd2, 32'd2, 32'd4, 32'd9,
                       32'd25, 32'd49, 32'd7, 32'd7, 32'd11, 32'd13, 32'd23,
                       32'd1000003, 32'd17, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                       32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'd1, 32'd0};
        queue_candidates(36);
        wait (candidates.size() == 0);

        send_idle_pct = 84;
        recv_idle_pct = 19;
        queue_candidates(40);
        wait (candidates.size() == 0);

        // No idling; the receiver stalls for a long stretch so the input backs up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_candidates(40);
        @(posedge clk);
        start_holdoff <= 1'b1;
        @(posedge clk);
        start_holdoff <= 1'b0;
        wait (candidates.size() == 0 && !s_axis_tvalid);

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d candidates through the tracker and checked %0d results.",
                 sent_count, results_seen);
        $display("Primes found: %0d, final last prime %0d, largest gap %0d, mismatches %0d.",
                 primes_seen, prev_prime, widest_gap, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
